// File: hw/rtl/armt_pkg.sv
// Package for the acknowledgement and retry message table.
// Holds shared codes, the slot entry layout and the controller/datapath bundles.
// No dependencies.
`default_nettype none

package armt_pkg;

  localparam int SLOTS_DEFAULT = 8;
  localparam logic [16:0] ID_WRAP = 17'd99999;

  localparam logic [31:0] RETRY_RESET = 32'd30000;
  localparam logic [7:0] MAXR_RESET = 8'd5;

  localparam logic [1:0] CFG_RETRY_IDX = 2'd0;
  localparam logic [1:0] CFG_MAXR_IDX = 2'd1;

  typedef enum logic [1:0] {
    F_ENQ = 2'd0,
    F_TICK = 2'd1,
    F_ACK = 2'd2,
    F_CANCEL = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    K_ENQ_OK = 4'd0,
    K_FULL = 4'd1,
    K_BAD = 4'd2,
    K_SEND = 4'd3,
    K_NOTICE = 4'd4,
    K_ACK_HIT = 4'd5,
    K_ACK_MISS = 4'd6,
    K_CANCEL_OK = 4'd7,
    K_CANCEL_REF = 4'd8,
    K_TDONE = 4'd9
  } kind_t;

  localparam logic [1:0] FIN_ACKED = 2'd0;
  localparam logic [1:0] FIN_CANCELLED = 2'd1;
  localparam logic [1:0] FIN_TIMEDOUT = 2'd2;

  localparam logic [2:0] ST_QUEUED = 3'd0;
  localparam logic [2:0] ST_PENDING = 3'd1;
  localparam logic [2:0] ST_ACKED = 3'd2;
  localparam logic [2:0] ST_CANCELLED = 3'd3;
  localparam logic [2:0] ST_TIMEDOUT = 3'd4;

  typedef enum logic [2:0] {
    E_NONE = 3'd0,
    E_ENQ = 3'd1,
    E_SEND = 3'd2,
    E_TONOTE = 3'd3,
    E_TDONE = 3'd4,
    E_NOTICE = 3'd5,
    E_HIT = 3'd6,
    E_MISS = 3'd7
  } emit_t;

  typedef struct packed {
    logic [7:0] client;
    logic [3:0] ssid;
    logic [16:0] id;
    logic [7:0] sends;
    logic [31:0] last_send;
    logic [31:0] qtime;
  } entry_t;

  typedef struct packed {
    logic cap;
    logic idx_clr;
    logic idx_inc;
    logic eval1;
    logic eval2;
    emit_t emit;
  } ctrl_t;

  typedef struct packed {
    func_t func;
    logic idx_last;
    logic pass_ok;
    logic send_now;
    logic to_now;
  } stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/ack_retry_message_table.sv
// Top level of the acknowledgement and retry message table.
// Depends on armt_pkg, armt_controller and armt_datapath.
`default_nettype none

// An item is taken when start is high while busy is low. Busy falls in the
// cycle in which the item's last result is on the result ports, so the next
// item can be taken in that same cycle. Every result appears for one cycle
// with result_valid high and cannot be held off, so the receiver must take it
// then; last marks the final result of an item. Each item first scans all
// SLOTS entries of the slot memory, with a read state and an evaluate state
// per slot because the memory read is registered. A tick then scans the
// table a second time to issue its sends, with an extra notice state for
// each message that times out. Each pass visits every slot once.
// Configuration writes are always accepted and must only be made while the
// block is idle.

module ack_retry_message_table import armt_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  func,
  input  wire logic [7:0]  requester,
  input  wire logic [3:0]  dest_sub,
  input  wire logic        payload_ok,
  input  wire logic [31:0] now_ms,
  input  wire logic [16:0] ack_id,
  input  wire logic        link_ready,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic             result_valid,
  output logic [3:0]       kind,
  output logic [2:0]       slot,
  output logic [16:0]      msg_id,
  output logic [7:0]       owner_client,
  output logic [3:0]       owner_ssid,
  output logic [7:0]       sends_done,
  output logic [1:0]       final_state,
  output logic [3:0]       count,
  output logic [31:0]      queued_time,
  output logic             last
);

  ctrl_t ctrl;
  stat_t stat;

  // Registers are plain flops with no side effects, so writes never wait.
  assign cfg_ready = 1'b1;

  armt_controller u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .ctrl (ctrl),
    .busy (busy)
  );

  armt_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .func        (func),
    .requester   (requester),
    .dest_sub    (dest_sub),
    .payload_ok  (payload_ok),
    .now_ms      (now_ms),
    .ack_id      (ack_id),
    .link_ready  (link_ready),
    .ctrl        (ctrl),
    .stat        (stat),
    .result_valid(result_valid),
    .kind        (kind),
    .slot        (slot),
    .msg_id      (msg_id),
    .owner_client(owner_client),
    .owner_ssid  (owner_ssid),
    .sends_done  (sends_done),
    .final_state (final_state),
    .count       (count),
    .queued_time (queued_time),
    .last        (last)
  );

endmodule

`default_nettype wire

// File: hw/rtl/armt_datapath.sv
// Datapath of the message table: slot memory, status flags, scan registers and results.
// Depends on armt_pkg; driven by armt_controller.
`default_nettype none

module armt_datapath import armt_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic [1:0]  func,
  input  wire logic [7:0]  requester,
  input  wire logic [3:0]  dest_sub,
  input  wire logic        payload_ok,
  input  wire logic [31:0] now_ms,
  input  wire logic [16:0] ack_id,
  input  wire logic        link_ready,
  input  wire ctrl_t       ctrl,
  output stat_t            stat,
  output logic             result_valid,
  output logic [3:0]       kind,
  output logic [2:0]       slot,
  output logic [16:0]      msg_id,
  output logic [7:0]       owner_client,
  output logic [3:0]       owner_ssid,
  output logic [7:0]       sends_done,
  output logic [1:0]       final_state,
  output logic [3:0]       count,
  output logic [31:0]      queued_time,
  output logic             last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  logic [31:0] retry_interval;
  logic [7:0] max_retries;

  func_t func_r;
  logic [7:0] client_r;
  logic [3:0] ssid_r;
  logic pay_ok_r;
  logic [31:0] now_r;
  logic [16:0] ack_r;
  logic link_r;

  logic [IW-1:0] idx;
  logic used [SLOTS];
  logic [2:0] status [SLOTS];
  entry_t mem [SLOTS];
  entry_t rdata;
  logic [16:0] id_counter;

  logic [CW-1:0] act_cnt;
  logic [CW-1:0] tick_after;
  logic [CW-1:0] tick_sends;
  logic fu_found, ff_found, m_found, m_active;
  logic [IW-1:0] fu_idx, ff_idx, m_idx;
  entry_t m_ent;
  entry_t h_ent;

  logic [2:0] st;
  logic u, active, ready_t, send_t, to_t, match_t, enq_hit;
  logic [31:0] elapsed;
  logic [7:0] ns;
  entry_t upd;
  logic [IW-1:0] sel;
  logic [16:0] id_new;
  logic we;
  logic [IW-1:0] waddr;
  entry_t wdata;

  logic result_valid_next;
  logic [3:0] kind_next;
  logic [2:0] slot_next;
  entry_t ent_next;
  logic [1:0] final_next;
  logic [CW-1:0] count_next;
  logic last_next;

  // Per-slot evaluation of the entry read in the previous cycle.
  always_comb begin
    st = status[idx];
    u = used[idx];
    active = u && (st == ST_QUEUED || st == ST_PENDING);
    elapsed = now_r - rdata.last_send;
    ready_t = (st == ST_QUEUED) || (elapsed >= retry_interval);
    send_t = active && ready_t && link_r;
    ns = rdata.sends + 8'd1;
    to_t = send_t && (ns >= max_retries);
    upd = rdata;
    upd.sends = ns;
    upd.last_send = now_r;
    if (func_r == F_ACK) begin
      match_t = active && (rdata.id == ack_r);
    end else begin
      match_t = u && (rdata.client == client_r);
    end
    enq_hit = fu_found || ff_found;
    sel = fu_found ? fu_idx : ff_idx;
    id_new = (id_counter == ID_WRAP) ? 17'd1 : id_counter + 17'd1;
  end

  always_comb begin
    we = 1'b0;
    waddr = idx;
    wdata = upd;
    if (ctrl.emit == E_ENQ && pay_ok_r && enq_hit) begin
      we = 1'b1;
      waddr = sel;
      wdata = '{client: client_r, ssid: ssid_r, id: id_new, sends: 8'd0,
                last_send: 32'd0, qtime: now_r};
    end else if (ctrl.eval2 && send_t) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_interval <= RETRY_RESET;
      max_retries <= MAXR_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_RETRY_IDX) begin
        retry_interval <= cfg_data;
      end else if (cfg_index == CFG_MAXR_IDX) begin
        max_retries <= cfg_data[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cap) begin
      func_r <= func_t'(func);
      client_r <= requester;
      ssid_r <= dest_sub;
      pay_ok_r <= payload_ok;
      now_r <= now_ms;
      ack_r <= ack_id;
      link_r <= link_ready;
    end
    if (ctrl.cap || ctrl.idx_clr) begin
      idx <= '0;
    end else if (ctrl.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        used[i] <= 1'b0;
      end
      id_counter <= '0;
    end else if (ctrl.emit == E_ENQ && pay_ok_r && enq_hit) begin
      used[sel] <= 1'b1;
      id_counter <= id_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit == E_ENQ && pay_ok_r && enq_hit) begin
      status[sel] <= ST_QUEUED;
    end else if (ctrl.eval2 && send_t) begin
      status[idx] <= to_t ? ST_TIMEDOUT : ST_PENDING;
    end else if (ctrl.emit == E_NOTICE) begin
      status[m_idx] <= (func_r == F_ACK) ? ST_ACKED : ST_CANCELLED;
    end
  end

  // First pass: counts and searches, no slot is changed; the second pass holds the updated entry.
  always_ff @(posedge clk) begin
    if (ctrl.cap) begin
      act_cnt <= '0;
      tick_after <= '0;
      tick_sends <= '0;
      fu_found <= 1'b0;
      ff_found <= 1'b0;
      m_found <= 1'b0;
    end else if (ctrl.eval1) begin
      act_cnt <= act_cnt + CW'(active);
      tick_after <= tick_after + CW'(active && !to_t);
      tick_sends <= tick_sends + CW'(send_t);
      if (!u && !fu_found) begin
        fu_found <= 1'b1;
        fu_idx <= idx;
      end
      if (u && !active && !ff_found) begin
        ff_found <= 1'b1;
        ff_idx <= idx;
      end
      if (match_t && !m_found) begin
        m_found <= 1'b1;
        m_idx <= idx;
        m_ent <= rdata;
        m_active <= active;
      end
    end
    if (ctrl.eval2) begin
      h_ent <= upd;
    end
  end

  always_comb begin
    stat.func = func_r;
    stat.idx_last = (idx == IW'(SLOTS - 1));
    stat.pass_ok = m_found && ((func_r == F_ACK) || m_active);
    stat.send_now = send_t;
    stat.to_now = to_t;
  end

  always_comb begin
    result_valid_next = 1'b0;
    kind_next = K_TDONE;
    slot_next = '0;
    ent_next = '0;
    final_next = FIN_ACKED;
    count_next = act_cnt;
    last_next = 1'b1;
    case (ctrl.emit)
      E_ENQ: begin
        result_valid_next = 1'b1;
        if (!pay_ok_r) begin
          kind_next = K_BAD;
        end else if (enq_hit) begin
          kind_next = K_ENQ_OK;
          slot_next = 3'(sel);
          ent_next = '{client: client_r, ssid: ssid_r, id: id_new, sends: 8'd0,
                       last_send: 32'd0, qtime: now_r};
          count_next = act_cnt + 1'b1;
        end else begin
          kind_next = K_FULL;
        end
      end
      E_SEND: begin
        result_valid_next = send_t;
        kind_next = K_SEND;
        slot_next = 3'(idx);
        ent_next = upd;
        count_next = tick_after;
        last_next = 1'b0;
      end
      E_TONOTE: begin
        result_valid_next = 1'b1;
        kind_next = K_NOTICE;
        slot_next = 3'(idx);
        ent_next = h_ent;
        final_next = FIN_TIMEDOUT;
        count_next = tick_after;
        last_next = 1'b0;
      end
      E_TDONE: begin
        result_valid_next = 1'b1;
        kind_next = K_TDONE;
        count_next = tick_sends;
      end
      E_NOTICE: begin
        result_valid_next = 1'b1;
        kind_next = K_NOTICE;
        slot_next = 3'(m_idx);
        ent_next = m_ent;
        final_next = (func_r == F_ACK) ? FIN_ACKED : FIN_CANCELLED;
        count_next = act_cnt - 1'b1;
        last_next = 1'b0;
      end
      E_HIT: begin
        result_valid_next = 1'b1;
        kind_next = (func_r == F_ACK) ? K_ACK_HIT : K_CANCEL_OK;
        slot_next = 3'(m_idx);
        ent_next = m_ent;
        count_next = act_cnt - 1'b1;
      end
      E_MISS: begin
        result_valid_next = 1'b1;
        if (func_r == F_ACK) begin
          kind_next = K_ACK_MISS;
          ent_next.id = ack_r;
        end else begin
          kind_next = K_CANCEL_REF;
          ent_next.client = client_r;
        end
      end
      default: begin
        result_valid_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
    end
    kind <= kind_next;
    slot <= slot_next;
    msg_id <= ent_next.id;
    owner_client <= ent_next.client;
    owner_ssid <= ent_next.ssid;
    sends_done <= ent_next.sends;
    final_state <= final_next;
    count <= 4'(count_next);
    queued_time <= ent_next.qtime;
    last <= last_next;
  end

  a_send_shown: assert property (@(posedge clk) disable iff (rst)
    ctrl.eval2 && send_t |=> result_valid && kind == K_SEND && !last)
    else $error("send result missing after a send");

  a_id_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == K_ENQ_OK |-> msg_id != 17'd0 && msg_id <= ID_WRAP)
    else $error("assigned id out of range");

  a_tdone_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == K_TDONE |-> last && final_state == FIN_ACKED)
    else $error("tick done not final");

endmodule

`default_nettype wire

// File: hw/rtl/armt_controller.sv
// Sequencing state machine of the message table.
// Depends on armt_pkg; commands armt_datapath.
`default_nettype none

module armt_controller import armt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire stat_t stat,
  output ctrl_t      ctrl,
  output logic       busy
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_P1_RD   = 9'b000000010,
    S_P1_EV   = 9'b000000100,
    S_DECIDE  = 9'b000001000,
    S_FIN     = 9'b000010000,
    S_P2_RD   = 9'b000100000,
    S_P2_EV   = 9'b001000000,
    S_TO_NOTE = 9'b010000000,
    S_TDONE   = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    ctrl = '{cap: 1'b0, idx_clr: 1'b0, idx_inc: 1'b0, eval1: 1'b0, eval2: 1'b0,
             emit: E_NONE};
    case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.cap = 1'b1;
          state_next = S_P1_RD;
        end
      end
      S_P1_RD: begin
        state_next = S_P1_EV;
      end
      S_P1_EV: begin
        ctrl.eval1 = 1'b1;
        if (stat.idx_last) begin
          state_next = S_DECIDE;
        end else begin
          ctrl.idx_inc = 1'b1;
          state_next = S_P1_RD;
        end
      end
      S_DECIDE: begin
        case (stat.func)
          F_ENQ: begin
            ctrl.emit = E_ENQ;
            state_next = S_IDLE;
          end
          F_TICK: begin
            ctrl.idx_clr = 1'b1;
            state_next = S_P2_RD;
          end
          default: begin
            if (stat.pass_ok) begin
              ctrl.emit = E_NOTICE;
              state_next = S_FIN;
            end else begin
              ctrl.emit = E_MISS;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_FIN: begin
        ctrl.emit = E_HIT;
        state_next = S_IDLE;
      end
      S_P2_RD: begin
        state_next = S_P2_EV;
      end
      S_P2_EV: begin
        ctrl.eval2 = 1'b1;
        ctrl.emit = E_SEND;
        if (stat.to_now) begin
          state_next = S_TO_NOTE;
        end else if (stat.idx_last) begin
          state_next = S_TDONE;
        end else begin
          ctrl.idx_inc = 1'b1;
          state_next = S_P2_RD;
        end
      end
      S_TO_NOTE: begin
        ctrl.emit = E_TONOTE;
        if (stat.idx_last) begin
          state_next = S_TDONE;
        end else begin
          ctrl.idx_inc = 1'b1;
          state_next = S_P2_RD;
        end
      end
      S_TDONE: begin
        ctrl.emit = E_TDONE;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  a_to_after_send: assert property (@(posedge clk) disable iff (rst)
    state == S_TO_NOTE |-> $past(state) == S_P2_EV && $past(stat.send_now))
    else $error("timeout notice without a send");

  a_fin_path: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN |-> $past(state) == S_DECIDE && $past(stat.pass_ok))
    else $error("hit result without a match");

  a_start_taken: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && start |=> state == S_P1_RD)
    else $error("start not taken while idle");

endmodule

`default_nettype wire

// File: tb/tb_ack_retry_message_table.sv
// Testbench for ack_retry_message_table: drives enqueue, tick, ack and cancel items,
// predicts every result with a scoreboard class and checks them in order.
// Depends on armt_pkg and the ack_retry_message_table RTL.
`default_nettype none

module tb_ack_retry_message_table;
  import armt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 8;

  // One result as the block reports it.
  typedef struct {
    kind_t       kind;
    logic [2:0]  slot;
    logic [16:0] msg_id;
    logic [7:0]  owner_client;
    logic [3:0]  owner_ssid;
    logic [7:0]  sends_done;
    logic [1:0]  final_state;
    logic [3:0]  count;
    logic [31:0] queued_time;
    logic        last;
  } notice_t;

  // The scoreboard keeps its own copy of the slot table and the registers, works out
  // the results of each accepted item and compares the block's results in order.
  class message_table_scoreboard;
    logic [31:0] retry_gap;
    logic [7:0]  send_limit;
    bit          used [NSLOT];
    logic [2:0]  status [NSLOT];
    logic [7:0]  client [NSLOT];
    logic [3:0]  ssid [NSLOT];
    logic [16:0] id [NSLOT];
    logic [7:0]  sends [NSLOT];
    logic [31:0] last_send [NSLOT];
    logic [31:0] qtime [NSLOT];
    logic [16:0] id_counter;
    notice_t     pending_results [$];
    int          errors;

    function void clear();
      retry_gap = RETRY_RESET;
      send_limit = MAXR_RESET;
      id_counter = 0;
      errors = 0;
      for (int i = 0; i < NSLOT; i++) begin
        used[i] = 0;
        status[i] = ST_QUEUED;
        client[i] = 0;
        ssid[i] = 0;
        id[i] = 0;
        sends[i] = 0;
        last_send[i] = 0;
        qtime[i] = 0;
      end
    endfunction

    function void write_register(logic [1:0] idx, logic [31:0] data);
      if (idx == CFG_RETRY_IDX) retry_gap = data;
      else if (idx == CFG_MAXR_IDX) send_limit = data[7:0];
    endfunction

    function bit finished(int s);
      return status[s] >= ST_ACKED;
    endfunction

    function notice_t slot_notice(kind_t k, int s, logic [1:0] fin);
      notice_t n;
      n = '{kind: k, slot: s[2:0], msg_id: id[s], owner_client: client[s],
            owner_ssid: ssid[s], sends_done: sends[s], final_state: fin,
            count: 0, queued_time: qtime[s], last: 0};
      return n;
    endfunction

    function notice_t empty_notice(kind_t k);
      notice_t n;
      n = '{kind: k, slot: 0, msg_id: 0, owner_client: 0, owner_ssid: 0,
            sends_done: 0, final_state: 0, count: 0, queued_time: 0, last: 0};
      return n;
    endfunction

    // Note an accepted item: update the table and queue its results.
    function void note_item(func_t f, logic [7:0] cid, logic [3:0] dssid, bit pay_ok,
                            logic [31:0] now, logic [16:0] ack, bit link);
      notice_t step_out [$];
      notice_t n;
      int s;
      int sent;
      int active;
      sent = 0;
      s = -1;
      case (f)
        F_ENQ: begin
          if (!pay_ok) begin
            step_out.push_back(empty_notice(K_BAD));
          end else begin
            for (int i = 0; i < NSLOT && s < 0; i++) if (!used[i]) s = i;
            for (int i = 0; i < NSLOT && s < 0; i++) if (used[i] && finished(i)) s = i;
            if (s < 0) begin
              step_out.push_back(empty_notice(K_FULL));
            end else begin
              id_counter = (id_counter % ID_WRAP) + 1;
              used[s] = 1;
              status[s] = ST_QUEUED;
              client[s] = cid;
              ssid[s] = dssid;
              id[s] = id_counter;
              sends[s] = 0;
              last_send[s] = 0;
              qtime[s] = now;
              step_out.push_back(slot_notice(K_ENQ_OK, s, 0));
            end
          end
        end
        F_TICK: begin
          for (int i = 0; i < NSLOT; i++) begin
            if (!used[i] || finished(i) || !link) continue;
            if (status[i] != ST_QUEUED && (now - last_send[i]) < retry_gap) continue;
            sends[i] = sends[i] + 1;
            last_send[i] = now;
            status[i] = ST_PENDING;
            sent++;
            step_out.push_back(slot_notice(K_SEND, i, 0));
            if (sends[i] >= send_limit) begin
              status[i] = ST_TIMEDOUT;
              step_out.push_back(slot_notice(K_NOTICE, i, FIN_TIMEDOUT));
            end
          end
          step_out.push_back(empty_notice(K_TDONE));
        end
        F_ACK: begin
          for (int i = 0; i < NSLOT && s < 0; i++)
            if (used[i] && !finished(i) && id[i] == ack) s = i;
          if (s >= 0) begin
            status[s] = ST_ACKED;
            step_out.push_back(slot_notice(K_NOTICE, s, FIN_ACKED));
            step_out.push_back(slot_notice(K_ACK_HIT, s, 0));
          end else begin
            n = empty_notice(K_ACK_MISS);
            n.msg_id = ack;
            step_out.push_back(n);
          end
        end
        default: begin
          for (int i = 0; i < NSLOT && s < 0; i++)
            if (used[i] && client[i] == cid) s = i;
          if (s >= 0 && !finished(s)) begin
            status[s] = ST_CANCELLED;
            step_out.push_back(slot_notice(K_NOTICE, s, FIN_CANCELLED));
            step_out.push_back(slot_notice(K_CANCEL_OK, s, 0));
          end else begin
            n = empty_notice(K_CANCEL_REF);
            n.owner_client = cid;
            step_out.push_back(n);
          end
        end
      endcase
      // The count field carries the active slots after the step, except on tick done.
      active = 0;
      for (int i = 0; i < NSLOT; i++) if (used[i] && !finished(i)) active++;
      foreach (step_out[k]) step_out[k].count = active[3:0];
      if (f == F_TICK) step_out[step_out.size() - 1].count = sent[3:0];
      step_out[step_out.size() - 1].last = 1;
      foreach (step_out[k]) pending_results.push_back(step_out[k]);
    endfunction

    function void check_result(notice_t got);
      notice_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind=%0d", $realtime, got.kind);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind)
        report("kind", want.kind, got.kind);
      if (got.slot !== want.slot)
        report("slot", want.slot, got.slot);
      if (got.msg_id !== want.msg_id)
        report("msg_id", want.msg_id, got.msg_id);
      if (got.owner_client !== want.owner_client)
        report("owner_client", want.owner_client, got.owner_client);
      if (got.owner_ssid !== want.owner_ssid)
        report("owner_ssid", want.owner_ssid, got.owner_ssid);
      if (got.sends_done !== want.sends_done)
        report("sends_done", want.sends_done, got.sends_done);
      if (got.final_state !== want.final_state)
        report("final_state", want.final_state, got.final_state);
      if (got.count !== want.count)
        report("count", want.count, got.count);
      if (got.queued_time !== want.queued_time)
        report("queued_time", want.queued_time, got.queued_time);
      if (got.last !== want.last)
        report("last", want.last, got.last);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $realtime, field, want, got);
      errors++;
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [1:0]  func = F_ENQ;
  logic [7:0]  requester = 0;
  logic [3:0]  dest_sub = 0;
  logic        payload_ok = 0;
  logic [31:0] now_ms = 0;
  logic [16:0] ack_id = 0;
  logic        link_ready = 0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_RETRY_IDX;
  logic [31:0] cfg_data = 0;
  logic        result_valid;
  logic [3:0]  kind;
  logic [2:0]  slot;
  logic [16:0] msg_id;
  logic [7:0]  owner_client;
  logic [3:0]  owner_ssid;
  logic [7:0]  sends_done;
  logic [1:0]  final_state;
  logic [3:0]  count;
  logic [31:0] queued_time;
  logic        last;

  message_table_scoreboard table_model = new();

  // Simulated millisecond clock; it moves forward with every random tick and wraps freely.
  logic [31:0] clock_ms;
  // Clients of the most recent enqueues, so that cancels often hit.
  logic [7:0]  client_pool [$];
  // When set, the sender adds no random idle cycles.
  bit          steady_sender;

  ack_retry_message_table dut (.*);

  always #6 clk = ~clk;

  // Every result is taken on the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && result_valid)
      table_model.check_result('{kind: kind_t'(kind), slot: slot, msg_id: msg_id,
                                 owner_client: owner_client, owner_ssid: owner_ssid,
                                 sends_done: sends_done, final_state: final_state,
                                 count: count, queued_time: queued_time, last: last});
  end

  // Present one item and hold it until the block takes it. Random idle cycles come
  // first unless the sender is in its steady stretch.
  task automatic send_item(func_t f, logic [7:0] cid, logic [3:0] dssid, bit pay_ok,
                           logic [31:0] now, logic [16:0] ack, bit link);
    while (!steady_sender && $urandom_range(99) < 22) @(posedge clk);
    start <= 1;
    func <= f;
    requester <= cid;
    dest_sub <= dssid;
    payload_ok <= pay_ok;
    now_ms <= now;
    ack_id <= ack;
    link_ready <= link;
    do @(posedge clk); while (busy);
    table_model.note_item(f, cid, dssid, pay_ok, now, ack, link);
    start <= 0;
    // Let busy rise before the next item looks at it.
    @(posedge clk);
  endtask

  // Wait until every expected result has come, then a margin for a block that
  // might still be finishing up.
  task automatic drain();
    while (table_model.pending_results.size() != 0 || busy) @(posedge clk);
    repeat (4 * NSLOT + 20) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    table_model.write_register(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Random items weighted toward well-formed traffic: enqueues from a small client
  // set, ticks that advance time by random amounts, and acks or cancels that
  // mostly name ids in the table and recent owners.
  task automatic random_item();
    int pick;
    logic [7:0] cid;
    logic [16:0] ack;
    pick = $urandom_range(99);
    cid = (client_pool.size() != 0 && $urandom_range(3) != 0)
          ? client_pool[$urandom_range(client_pool.size() - 1)] : 8'($urandom);
    if (pick < 35) begin
      cid = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15));
      client_pool.push_back(cid);
      if (client_pool.size() > 12) void'(client_pool.pop_front());
      send_item(F_ENQ, cid, 4'($urandom), $urandom_range(9) != 0, clock_ms, 17'($urandom),
                1'($urandom));
    end else if (pick < 70) begin
      clock_ms = clock_ms + (($urandom_range(3) == 0) ? $urandom : $urandom_range(40000));
      send_item(F_TICK, 8'($urandom), 4'($urandom), 1'($urandom), clock_ms, 17'($urandom),
                $urandom_range(7) != 0);
    end else if (pick < 88) begin
      if ($urandom_range(4) == 0) ack = 17'($urandom);
      else ack = table_model.id[$urandom_range(NSLOT - 1)];
      if (!table_model.used[ack[2:0]] && ack == 0) ack = 17'($urandom_range(1, 20));
      send_item(F_ACK, cid, 4'($urandom), 1'($urandom), 32'($urandom), ack, 1'($urandom));
    end else begin
      send_item(F_CANCEL, cid, 4'($urandom), 1'($urandom), 32'($urandom), 17'($urandom),
                1'($urandom));
    end
  endtask

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    table_model.clear();
    steady_sender = 0;
    clock_ms = 32'hFFFF_0000;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part with the reset registers: fill the table past full, bad
    // parameter while full, ticks, acks with ids zero, out of range and live, cancels.
    send_item(F_ENQ, 8'h00, 4'h0, 0, 32'h0, 17'h0, 0);
    for (int i = 0; i < NSLOT; i++)
      send_item(F_ENQ, 8'(i == 7 ? 8'hFF : i), 4'(i == 7 ? 15 : i), 1, clock_ms + i, 0, 0);
    send_item(F_ENQ, 8'h55, 4'hA, 1, 32'hFFFF_FFFF, 17'h1FFFF, 1);
    send_item(F_ENQ, 8'h55, 4'hA, 0, 32'h0, 0, 1);
    send_item(F_TICK, 0, 0, 0, clock_ms, 0, 0);
    send_item(F_TICK, 0, 0, 0, clock_ms, 0, 1);
    send_item(F_TICK, 0, 0, 0, clock_ms + 29999, 0, 1);
    send_item(F_TICK, 0, 0, 0, clock_ms + 30000 + 32'h1_0000, 0, 1);
    send_item(F_ACK, 0, 0, 0, 0, 17'd0, 0);
    send_item(F_ACK, 0, 0, 0, 0, 17'd100000, 0);
    send_item(F_ACK, 0, 0, 0, 0, 17'h1FFFF, 0);
    send_item(F_ACK, 0, 0, 0, 0, 17'd3, 0);
    send_item(F_ACK, 0, 0, 0, 0, 17'd3, 0);
    send_item(F_CANCEL, 8'hFF, 0, 0, 0, 0, 0);
    send_item(F_CANCEL, 8'hFF, 0, 0, 0, 0, 0);
    send_item(F_CANCEL, 8'hAB, 0, 0, 0, 0, 0);
    send_item(F_CANCEL, 8'h02, 0, 0, 0, 0, 0);
    send_item(F_ENQ, 8'h33, 4'h3, 1, 32'h1234_5678, 0, 0);
    drain();

    // Extremes: no wait and a single send, so each tick times every message out.
    write_register(CFG_RETRY_IDX, 32'd0);
    write_register(CFG_MAXR_IDX, 32'd1);
    clock_ms = 0;
    send_item(F_TICK, 0, 0, 0, clock_ms, 0, 1);
    for (int i = 0; i < 6; i++) send_item(F_ENQ, 8'(8'hF0 + i), 4'(i), 1, i, 0, 0);
    send_item(F_TICK, 0, 0, 0, clock_ms, 0, 1);
    drain();

    // Largest interval and retry limit, with a stretch where the sender adds no random idle cycles.
    write_register(CFG_RETRY_IDX, 32'hFFFF_FFFF);
    write_register(CFG_MAXR_IDX, 32'd255);
    steady_sender = 1;
    repeat (40) random_item();
    steady_sender = 0;
    drain();

    // Short intervals and few retries make timeouts and finished-slot reuse common.
    write_register(CFG_RETRY_IDX, 32'd1000);
    write_register(CFG_MAXR_IDX, 32'd3);
    repeat (90) random_item();
    drain();

    write_register(CFG_RETRY_IDX, 32'd30000);
    write_register(CFG_MAXR_IDX, 32'd5);
    repeat (90) random_item();
    drain();

    if (table_model.errors == 0 && table_model.pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
